// ===== hdl/text_console_char_writer_defines.svh =====
// Assertion macros used by the console writer sequencer.
`ifndef TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define TCW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hdl/tcw_pkg.sv =====
// Package of the text console writer: constants, types and the state enum.
package tcw_pkg;
    localparam int COLUMNS_DEF      = 80;
    localparam int ROWS_DEF         = 25;
    localparam int ESCAPE_LIMIT_DEF = 20;

    localparam logic [7:0] ESC_CODE   = 8'd27;
    localparam logic [7:0] TAB_CODE   = 8'd9;
    localparam logic [7:0] BS_CODE    = 8'd8;
    localparam logic [7:0] LF_CODE    = 8'd10;
    localparam logic [7:0] CR_CODE    = 8'd13;
    localparam logic [7:0] SPACE_CODE = 8'd32;
    localparam logic [7:0] RESET_ATTR = 8'h07;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [2:0] REG_WIN_LEFT   = 3'd0;
    localparam logic [2:0] REG_WIN_TOP    = 3'd1;
    localparam logic [2:0] REG_WIN_RIGHT  = 3'd2;
    localparam logic [2:0] REG_WIN_BOTTOM = 3'd3;
    localparam logic [2:0] REG_TEXT_ATTR  = 3'd4;
    localparam logic [2:0] REG_SCROLL_EN  = 3'd5;

    typedef struct packed {
        logic       operation;
        logic [7:0] char_byte;
        logic [10:0] cell_address;
    } in_item_t;

    typedef struct packed {
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic       in_escape;
        logic       escape_done;
        logic [7:0] final_letter;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
    } out_item_t;

    typedef struct packed {
        logic [6:0] win_left;
        logic [4:0] win_top;
        logic [6:0] win_right;
        logic [4:0] win_bottom;
        logic [7:0] text_attr;
        logic       scroll_enable;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_READ_WAIT,
        ST_READ_DONE,
        ST_NEWLINE,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_BLANK,
        ST_OUTPUT
    } state_t;

    // Memory request from the sequencer to the screen store.
    typedef struct packed {
        logic        wr_en;
        logic [10:0] wr_addr;
        logic [15:0] wr_data;
        logic [10:0] rd_addr;
    } mem_req_t;
endpackage

// ===== hdl/tcw_stream_if.sv =====
// Valid/ready stream interface with a generic payload.
interface tcw_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/tcw_screen_ram.sv =====
// Screen store: one write port and one registered read port.
module tcw_screen_ram #(
    parameter int DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF
) (
    input  logic              clk,
    input  tcw_pkg::mem_req_t req,
    output logic [15:0]       rd_data
);
    localparam int AW = $clog2(DEPTH);
    logic [15:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (req.wr_en && (32'(req.wr_addr) < DEPTH))
        begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
        rd_data <= mem[req.rd_addr[AW-1:0]];
    end
endmodule

// ===== hdl/tcw_sequencer.sv =====
// Sequencer: decodes bytes, moves the cursor and drives the screen store.
`include "text_console_char_writer_defines.svh"
module tcw_sequencer #(
    parameter int ESCAPE_LIMIT = tcw_pkg::ESCAPE_LIMIT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tcw_pkg::cfg_t      cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  tcw_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output tcw_pkg::out_item_t out_item,
    output tcw_pkg::mem_req_t  mem_req,
    input  logic [15:0]        rd_data
);
    localparam int COLUMNS = tcw_pkg::COLUMNS_DEF;
    localparam int ROWS    = tcw_pkg::ROWS_DEF;
    localparam int CELLS = COLUMNS * ROWS;
    localparam int CW    = $clog2(CELLS + 1);
    localparam int EW    = $clog2(ESCAPE_LIMIT + 1);
    localparam logic [6:0] MAXCOL = 7'(COLUMNS - 1);
    localparam logic [4:0] MAXROW = 5'(ROWS - 1);
    localparam logic [10:0] COLS11 = 11'(COLUMNS);

    tcw_pkg::state_t state_reg, state_next;
    logic [6:0]  cx_reg, cx_next;
    logic [4:0]  cy_reg, cy_next;
    logic        esc_reg, esc_next;
    logic [EW-1:0] ecnt_reg, ecnt_next;
    tcw_pkg::in_item_t item_reg, item_next;
    logic        done_reg, done_next;
    logic [7:0]  letter_reg, letter_next;
    logic [15:0] cell_reg, cell_next;
    logic [CW-1:0] clr_reg, clr_next;
    logic [4:0]  sy_reg, sy_next;
    logic [6:0]  sx_reg, sx_next;
    logic [10:0] base_reg, base_next;

    logic [6:0] right_e;
    logic [4:0] bot_e;
    logic       left_ok;
    logic [7:0] c;
    logic       is_letter;
    logic [10:0] cur_addr;

    // Effective window edges and the current cell address.
    always_comb
    begin
        right_e  = (cfg.win_right > MAXCOL) ? MAXCOL : cfg.win_right;
        bot_e    = (cfg.win_bottom > MAXROW) ? MAXROW : cfg.win_bottom;
        c        = item_reg.char_byte;
        is_letter = (c >= 8'd97 && c <= 8'd122) || (c >= 8'd65 && c <= 8'd90);
        cur_addr = 11'(32'(cy_reg) * COLUMNS) + 11'(cx_reg);
        left_ok  = (cfg.win_left <= right_e) && (cy_next >= cfg.win_top) && (cy_next <= bot_e);
    end

    // Registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcw_pkg::ST_CLEAR;
            cx_reg <= '0;
            cy_reg <= '0;
            esc_reg <= 1'b0;
            ecnt_reg <= '0;
            clr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            esc_reg <= esc_next;
            ecnt_reg <= ecnt_next;
            clr_reg <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        done_reg <= done_next;
        letter_reg <= letter_next;
        cell_reg <= cell_next;
        sy_reg <= sy_next;
        sx_reg <= sx_next;
        base_reg <= base_next;
    end

    // Next state and datapath.
    always_comb
    begin
        state_next = state_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        esc_next = esc_reg;
        ecnt_next = ecnt_reg;
        item_next = item_reg;
        done_next = done_reg;
        letter_next = letter_reg;
        cell_next = cell_reg;
        clr_next = clr_reg;
        sy_next = sy_reg;
        sx_next = sx_reg;
        base_next = base_reg;
        mem_req = '0;
        mem_req.rd_addr = base_reg + COLS11 + 11'(sx_reg);
        unique case (state_reg)
            tcw_pkg::ST_CLEAR:
            begin
                mem_req.wr_en = 1'b1;
                mem_req.wr_addr = 11'(clr_reg);
                mem_req.wr_data = {tcw_pkg::RESET_ATTR, tcw_pkg::SPACE_CODE};
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == CELLS - 1)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next = in_item;
                    done_next = 1'b0;
                    letter_next = '0;
                    cell_next = '0;
                    state_next = (in_item.operation == tcw_pkg::OP_READ)
                                 ? tcw_pkg::ST_READ_WAIT : tcw_pkg::ST_DECODE;
                end
            end
            tcw_pkg::ST_READ_WAIT:
            begin
                mem_req.rd_addr = item_reg.cell_address;
                state_next = tcw_pkg::ST_READ_DONE;
            end
            tcw_pkg::ST_READ_DONE:
            begin
                cell_next = (32'(item_reg.cell_address) < CELLS) ? rd_data : 16'h0;
                state_next = tcw_pkg::ST_OUTPUT;
            end
            tcw_pkg::ST_DECODE:
            begin
                state_next = tcw_pkg::ST_OUTPUT;
                if (esc_reg && c != tcw_pkg::ESC_CODE)
                begin
                    esc_next = 1'b0;
                    ecnt_next = ecnt_reg + 1'b1;
                    if (is_letter)
                    begin
                        done_next = 1'b1;
                        letter_next = c;
                    end
                    else if (32'(ecnt_reg) + 1 < ESCAPE_LIMIT)
                    begin
                        esc_next = 1'b1;
                    end
                end
                if (!(esc_reg && c != tcw_pkg::ESC_CODE && (is_letter
                      || 32'(ecnt_reg) + 1 < ESCAPE_LIMIT)))
                begin
                    esc_next = 1'b0;
                    case (c)
                        tcw_pkg::TAB_CODE:
                        begin
                        end
                        tcw_pkg::BS_CODE:
                        begin
                            if (cx_reg > cfg.win_left)
                            begin
                                cx_next = cx_reg - 1'b1;
                                mem_req.wr_en = (32'(cy_reg) < ROWS);
                                mem_req.wr_addr = cur_addr - 11'd1;
                                mem_req.wr_data = {cfg.text_attr, tcw_pkg::SPACE_CODE};
                            end
                        end
                        tcw_pkg::LF_CODE:
                        begin
                            if (left_ok)
                            begin
                                cx_next = cfg.win_left;
                            end
                            state_next = tcw_pkg::ST_NEWLINE;
                        end
                        tcw_pkg::CR_CODE:
                        begin
                            if (left_ok)
                            begin
                                cx_next = cfg.win_left;
                            end
                        end
                        tcw_pkg::ESC_CODE:
                        begin
                            esc_next = 1'b1;
                            ecnt_next = '0;
                        end
                        default:
                        begin
                            mem_req.wr_en = (32'(cy_reg) < ROWS) && (32'(cx_reg) < COLUMNS);
                            mem_req.wr_addr = cur_addr;
                            mem_req.wr_data = {cfg.text_attr, c};
                            cx_next = cx_reg + 1'b1;
                            if (cx_reg + 1'b1 > right_e)
                            begin
                                if (left_ok)
                                begin
                                    cx_next = cfg.win_left;
                                end
                                state_next = tcw_pkg::ST_NEWLINE;
                            end
                            else if (cx_reg + 1'b1 > MAXCOL)
                            begin
                                cx_next = MAXCOL;
                            end
                        end
                    endcase
                end
            end
            tcw_pkg::ST_NEWLINE:
            begin
                // Step down one row, scrolling at the bottom edge when scrolling is enabled.
                state_next = tcw_pkg::ST_OUTPUT;
                cy_next = cy_reg + 1'b1;
                if (cy_reg + 1'b1 > bot_e)
                begin
                    cy_next = bot_e;
                    if (cfg.scroll_enable)
                    begin
                        sy_next = cfg.win_top;
                        sx_next = cfg.win_left;
                        base_next = 11'(32'(cfg.win_top) * COLUMNS);
                        state_next = (cfg.win_top < bot_e && cfg.win_left <= right_e)
                                     ? tcw_pkg::ST_SCROLL_RD : tcw_pkg::ST_BLANK;
                        if (!(cfg.win_left <= right_e))
                        begin
                            state_next = tcw_pkg::ST_OUTPUT;
                        end
                        else if (!(cfg.win_top < bot_e))
                        begin
                            base_next = 11'(32'(bot_e) * COLUMNS);
                        end
                    end
                end
                if (left_ok)
                begin
                    cx_next = cfg.win_left;
                end
                if (cx_next > MAXCOL)
                begin
                    cx_next = MAXCOL;
                end
            end
            tcw_pkg::ST_SCROLL_RD:
            begin
                // Read the cell one row below.
                state_next = tcw_pkg::ST_SCROLL_WR;
            end
            tcw_pkg::ST_SCROLL_WR:
            begin
                mem_req.wr_en = 1'b1;
                mem_req.wr_addr = base_reg + 11'(sx_reg);
                mem_req.wr_data = rd_data;
                state_next = tcw_pkg::ST_SCROLL_RD;
                sx_next = sx_reg + 1'b1;
                if (sx_reg == right_e)
                begin
                    sx_next = cfg.win_left;
                    sy_next = sy_reg + 1'b1;
                    base_next = base_reg + COLS11;
                    if (sy_reg + 1'b1 == bot_e)
                    begin
                        state_next = tcw_pkg::ST_BLANK;
                    end
                end
            end
            tcw_pkg::ST_BLANK:
            begin
                mem_req.wr_en = 1'b1;
                mem_req.wr_addr = base_reg + 11'(sx_reg);
                mem_req.wr_data = {cfg.text_attr, tcw_pkg::SPACE_CODE};
                sx_next = sx_reg + 1'b1;
                if (sx_reg == right_e)
                begin
                    state_next = tcw_pkg::ST_OUTPUT;
                end
            end
            tcw_pkg::ST_OUTPUT:
            begin
                if (out_ready)
                begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        in_ready = (state_reg == tcw_pkg::ST_IDLE);
        out_valid = (state_reg == tcw_pkg::ST_OUTPUT);
        out_item.cursor_col = cx_reg;
        out_item.cursor_row = cy_reg;
        out_item.in_escape = esc_reg;
        out_item.escape_done = done_reg;
        out_item.final_letter = letter_reg;
        out_item.cell_char = cell_reg[7:0];
        out_item.cell_attr = cell_reg[15:8];
    end

    `TCW_ASSERT_IMP(a_no_both, clk, rst_n, 1'b1, !(in_ready && out_valid))
    `TCW_ASSERT_IMP(a_row_range, clk, rst_n, out_valid, 32'(cy_reg) < ROWS)
    `TCW_ASSERT_IMP(a_col_range, clk, rst_n, out_valid, 32'(cx_reg) < COLUMNS)
    `TCW_ASSERT_NEXT(a_done_letter, clk, rst_n, out_valid && done_reg, !esc_reg || !out_ready)
endmodule

// ===== hdl/text_console_char_writer.sv =====
// Top level of the text console character writer.
//  channel  | dir | payload
//  in_ch    | in  | operation, char_byte, cell_address
//  out_ch   | out | cursor_col/row, escape flags, cell_char, cell_attr
//  cfg_*    | in  | cfg_index (3 bits), cfg_data (8 bits)
// An item holds the block until its result is taken: a read passes READ_WAIT
// and READ_DONE, a byte DECODE, and also NEWLINE when it moves to a new line.
// A scroll copies each cell through SCROLL_RD and SCROLL_WR and then blanks
// the bottom window row in BLANK, one cell at a time.
// After reset a clearing pass blanks the store; no item is accepted
// meanwhile. A stalled result holds the block.
module text_console_char_writer #(
    parameter int ESCAPE_LIMIT = tcw_pkg::ESCAPE_LIMIT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tcw_stream_if.sink  in_ch,
    tcw_stream_if.source out_ch,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    localparam int COLUMNS = tcw_pkg::COLUMNS_DEF;
    localparam int ROWS    = tcw_pkg::ROWS_DEF;

    tcw_pkg::cfg_t     cfg_reg;
    tcw_pkg::mem_req_t mem_req;
    logic [15:0]       rd_data;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.win_left <= 7'd0;
            cfg_reg.win_top <= 5'd0;
            cfg_reg.win_right <= 7'd79;
            cfg_reg.win_bottom <= 5'd24;
            cfg_reg.text_attr <= tcw_pkg::RESET_ATTR;
            cfg_reg.scroll_enable <= 1'b1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tcw_pkg::REG_WIN_LEFT:   cfg_reg.win_left <= cfg_data[6:0];
                tcw_pkg::REG_WIN_TOP:    cfg_reg.win_top <= cfg_data[4:0];
                tcw_pkg::REG_WIN_RIGHT:  cfg_reg.win_right <= cfg_data[6:0];
                tcw_pkg::REG_WIN_BOTTOM: cfg_reg.win_bottom <= cfg_data[4:0];
                tcw_pkg::REG_TEXT_ATTR:  cfg_reg.text_attr <= cfg_data;
                tcw_pkg::REG_SCROLL_EN:  cfg_reg.scroll_enable <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    tcw_sequencer #(.ESCAPE_LIMIT(ESCAPE_LIMIT)) u_seq (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_ch.payload),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item(out_ch.payload),
        .mem_req(mem_req), .rd_data(rd_data)
    );

    tcw_screen_ram #(.DEPTH(COLUMNS * ROWS)) u_ram (
        .clk(clk), .req(mem_req), .rd_data(rd_data)
    );
endmodule
